FILE: design/hdfs_pkg.sv
// hdfs_pkg: shared types and constants for the http/2 data frame segmenter
// used by hdfs_framer, hdfs_emitter and the top level
`timescale 1ns / 1ps

package hdfs_pkg;

  localparam logic [23:0] MIN_FRAME       = 24'd16384;
  localparam logic [7:0]  FLAG_STREAM_END = 8'h01;
  localparam logic [7:0]  FLAG_PADDED     = 8'h08;

  // beat numbering of one run: header bytes 0..8, payload byte last
  localparam logic [3:0]  HDR_BEATS = 4'd9;
  localparam logic [3:0]  PAY_BEAT  = 4'd9;

  localparam logic [3:0]  BEAT_LEN_HI  = 4'd0;
  localparam logic [3:0]  BEAT_LEN_MID = 4'd1;
  localparam logic [3:0]  BEAT_LEN_LO  = 4'd2;
  localparam logic [3:0]  BEAT_TYPE    = 4'd3;
  localparam logic [3:0]  BEAT_FLAGS   = 4'd4;
  localparam logic [3:0]  BEAT_SID_3   = 4'd5;
  localparam logic [3:0]  BEAT_SID_2   = 4'd6;
  localparam logic [3:0]  BEAT_SID_1   = 4'd7;
  localparam logic [3:0]  BEAT_SID_0   = 4'd8;

  // one accepted payload byte and everything needed to emit its run
  typedef struct packed {
    logic        with_header;
    logic [23:0] frame_len;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] strm_id;
    logic [7:0]  data_byte;
    logic        end_of_frame;
    logic        end_of_message;
  } run_desc_t;

endpackage

FILE: design/hdfs_framer.sv
// hdfs_framer: message and frame bookkeeping, one accepted byte per cycle
// depends on hdfs_pkg (run_desc_t, frame constants)
`timescale 1ns / 1ps

module hdfs_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr,
  input  logic [23:0]         cfg_data,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic [31:0]         message_length,
  input  logic [30:0]         strm_id,
  input  logic [7:0]          frame_type,
  input  logic [7:0]          frame_flags,
  output logic                desc_valid,
  output hdfs_pkg::run_desc_t desc
);

  logic [23:0] frame_limit;
  logic [31:0] bytes_consumed;
  logic [23:0] frame_bytes_left;
  logic [31:0] held_length;
  logic [30:0] held_stream;
  logic [7:0]  held_type;
  logic [7:0]  held_flags;

  logic        idle;
  logic        drop;
  logic [31:0] len_eff;
  logic [7:0]  flags_eff;
  logic [23:0] fleft_eff;
  logic        new_frame;
  logic [23:0] limit;
  logic [31:0] remain;
  logic        last_frame;
  logic [23:0] flen;
  logic [23:0] left_after;
  logic [31:0] consumed_after;
  logic        eof;
  logic        eom;
  logic [7:0]  hdr_flags;

  always_comb begin
    idle      = (bytes_consumed == 32'd0);
    drop      = idle && (message_length == 32'd0);
    len_eff   = idle ? message_length : held_length;
    flags_eff = idle ? (frame_flags & ~hdfs_pkg::FLAG_PADDED) : held_flags;
    fleft_eff = idle ? 24'd0 : frame_bytes_left;
    new_frame = (fleft_eff == 24'd0);
    limit     = (frame_limit < hdfs_pkg::MIN_FRAME) ? hdfs_pkg::MIN_FRAME : frame_limit;
    remain    = len_eff - bytes_consumed;
    last_frame = (remain <= {8'd0, limit});
    flen      = last_frame ? remain[23:0] : limit;
    hdr_flags = (flags_eff & ~hdfs_pkg::FLAG_STREAM_END)
              | (last_frame ? (flags_eff & hdfs_pkg::FLAG_STREAM_END) : 8'd0);
    left_after     = (new_frame ? flen : fleft_eff) - 24'd1;
    consumed_after = bytes_consumed + 32'd1;
    eof = new_frame ? (flen == 24'd1) : (fleft_eff == 24'd1);
    eom = (consumed_after == len_eff);

    desc_valid          = accept && !drop;
    desc.with_header    = new_frame;
    desc.frame_len      = flen;
    desc.frame_type     = idle ? frame_type : held_type;
    desc.frame_flags    = hdr_flags;
    desc.strm_id        = idle ? strm_id : held_stream;
    desc.data_byte      = data_byte;
    desc.end_of_frame   = eof;
    desc.end_of_message = eom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit      <= hdfs_pkg::MIN_FRAME;
      bytes_consumed   <= 32'd0;
      frame_bytes_left <= 24'd0;
    end else begin
      if (cfg_wr) begin
        frame_limit <= cfg_data;
      end
      if (desc_valid) begin
        if (eom) begin
          bytes_consumed   <= 32'd0;
          frame_bytes_left <= 24'd0;
        end else begin
          bytes_consumed   <= consumed_after;
          frame_bytes_left <= left_after;
        end
      end
    end
  end

  // message header fields, latched on the first byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held_length <= 32'd0;
      held_stream <= 31'd0;
      held_type   <= 8'd0;
      held_flags  <= 8'd0;
    end else if (desc_valid && idle) begin
      held_length <= message_length;
      held_stream <= strm_id;
      held_type   <= frame_type;
      held_flags  <= frame_flags & ~hdfs_pkg::FLAG_PADDED;
    end
  end

endmodule

FILE: design/hdfs_emitter.sv
// hdfs_emitter: holding slot plus output run register, serializes header and payload
// depends on hdfs_pkg (run_desc_t, beat constants)
`timescale 1ns / 1ps

module hdfs_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_valid,
  input  hdfs_pkg::run_desc_t desc,
  output logic                desc_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                is_header,
  output logic                end_of_frame,
  output logic                end_of_message,
  output logic                last_of_run
);

  hdfs_pkg::run_desc_t slot;
  logic                slot_valid;
  hdfs_pkg::run_desc_t run;
  logic                run_valid;
  logic [3:0]          beat;

  logic run_done;
  logic slot_take;

  always_comb begin
    run_done   = run_valid && (beat == hdfs_pkg::PAY_BEAT) && out_ready;
    slot_take  = slot_valid && (!run_valid || run_done);
    desc_ready = !slot_valid || slot_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      run_valid  <= 1'b0;
      beat       <= 4'd0;
    end else begin
      if (desc_valid) begin
        slot_valid <= 1'b1;
      end else if (slot_take) begin
        slot_valid <= 1'b0;
      end
      if (slot_take) begin
        run_valid <= 1'b1;
        beat      <= slot.with_header ? hdfs_pkg::BEAT_LEN_HI : hdfs_pkg::PAY_BEAT;
      end else if (run_done) begin
        run_valid <= 1'b0;
      end else if (run_valid && out_ready) begin
        beat <= beat + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid) begin
      slot <= desc;
    end
    if (slot_take) begin
      run <= slot;
    end
  end

  always_comb begin
    unique case (beat)
      hdfs_pkg::BEAT_LEN_HI:  out_byte = run.frame_len[23:16];
      hdfs_pkg::BEAT_LEN_MID: out_byte = run.frame_len[15:8];
      hdfs_pkg::BEAT_LEN_LO:  out_byte = run.frame_len[7:0];
      hdfs_pkg::BEAT_TYPE:    out_byte = run.frame_type;
      hdfs_pkg::BEAT_FLAGS:   out_byte = run.frame_flags;
      hdfs_pkg::BEAT_SID_3:   out_byte = {1'b0, run.strm_id[30:24]};
      hdfs_pkg::BEAT_SID_2:   out_byte = run.strm_id[23:16];
      hdfs_pkg::BEAT_SID_1:   out_byte = run.strm_id[15:8];
      hdfs_pkg::BEAT_SID_0:   out_byte = run.strm_id[7:0];
      default:                out_byte = run.data_byte;
    endcase
    out_valid      = run_valid;
    is_header      = (beat < hdfs_pkg::HDR_BEATS);
    last_of_run    = (beat == hdfs_pkg::PAY_BEAT);
    end_of_frame   = last_of_run && run.end_of_frame;
    end_of_message = last_of_run && run.end_of_message;
  end

endmodule

FILE: design/http2_data_frame_segmenter_core.sv
// http2_data_frame_segmenter_core: top level of the http/2 data frame segmenter
// depends on hdfs_pkg, hdfs_framer, hdfs_emitter
`timescale 1ns / 1ps

// usage
//   s_* stream: one payload byte per transaction; message length, stream id,
//     type and flags ride along and are sampled on a message's first byte only
//   m_* stream: one wire byte per transaction, 9 header bytes before the first
//     payload byte of every frame; tlast closes the bytes caused by one input
//   cfg_*: write of the frame size limit, always ready, values below 16384 act
//     as 16384; a new value applies from the next frame boundary
// each input byte passes through the holding slot and then the output register
// throughput: one payload byte per cycle inside a frame while m_tready is high;
//   a byte that opens a frame sends 9 header bytes and then itself over the
//   single output byte lane, and the input stalls once the holding slot fills
// a zero-length message byte is accepted and dropped, giving no output
// reset (rst, synchronous) empties the holding slot and the output register,
//   ends any message in progress and restores the frame size limit to 16384
// when m_tready is low the output register and one holding slot fill, then
//   s_tready drops; nothing is lost or repeated
module http2_data_frame_segmenter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,     // frame size limit
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: data_byte[7:0], message_length[39:8], strm_id[70:40],
  //   frame_type[78:71], frame_flags[86:79], zero pad [87]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // out_byte
  output logic [2:0]  m_tuser,      // is_header[0], end_of_frame[1], end_of_message[2]
  output logic        m_tlast       // last_of_run
);

  logic                s_accept;
  logic                desc_valid;
  logic                desc_ready;
  hdfs_pkg::run_desc_t desc;
  logic                is_header;
  logic                end_of_frame;
  logic                end_of_message;

  // user must land register writes only while idle, unenforced; cfg never pushes back
  assign cfg_ready = 1'b1;
  assign s_tready  = desc_ready;
  assign s_accept  = s_tvalid && desc_ready;

  // per-byte bookkeeping and header field selection
  hdfs_framer u_framer (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr         (cfg_valid),
    .cfg_data       (cfg_data),
    .accept         (s_accept),
    .data_byte      (s_tdata[7:0]),
    .message_length (s_tdata[39:8]),
    .strm_id        (s_tdata[70:40]),
    .frame_type     (s_tdata[78:71]),
    .frame_flags    (s_tdata[86:79]),
    .desc_valid     (desc_valid),
    .desc           (desc)
  );

  // slot and output register, walks each run out a byte per transaction
  hdfs_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .desc_valid     (desc_valid),
    .desc           (desc),
    .desc_ready     (desc_ready),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (m_tdata),
    .is_header      (is_header),
    .end_of_frame   (end_of_frame),
    .end_of_message (end_of_message),
    .last_of_run    (m_tlast)
  );

  assign m_tuser = {end_of_message, end_of_frame, is_header};

endmodule

FILE: design/hdfs_checker.sv
// hdfs_checker: port-level assertions for http2_data_frame_segmenter_core
// bound to the top level; no package dependencies
`timescale 1ns / 1ps

module hdfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  // stalled output transaction holds its content
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output changed while stalled");

  // header bytes never carry frame or message ends and never close a run
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tuser[2] && !m_tlast)
    else $error("header byte with end marks");

  // end of message is always also end of frame
  a_eom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1])
    else $error("end of message without end of frame");

  // payload bytes are always the last of their run
  a_pay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("payload byte not last of run");

endmodule

bind http2_data_frame_segmenter_core hdfs_checker u_hdfs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
